@@ hw/rtl/tpc_pkg.sv @@
// Shared types, widths, codes and cut-divider step functions for the
// triangle plane clipper. Depends on nothing; used by every other file.
`timescale 1ns / 1ps

package tpc_pkg;

    localparam int CW  = 32;          // coordinate width, signed Q16.16
    localparam int PRW = 2 * CW + 1;  // product of normal and vertex offset
    localparam int DW  = 2 * CW + 3;  // signed distance and cut divisor

    localparam int CFG_IW = 3;
    localparam logic [CFG_IW-1:0] REG_PLANE_X  = 3'd0;
    localparam logic [CFG_IW-1:0] REG_PLANE_Y  = 3'd1;
    localparam logic [CFG_IW-1:0] REG_PLANE_Z  = 3'd2;
    localparam logic [CFG_IW-1:0] REG_NORMAL_X = 3'd3;
    localparam logic [CFG_IW-1:0] REG_NORMAL_Y = 3'd4;
    localparam logic [CFG_IW-1:0] REG_NORMAL_Z = 3'd5;

    // How many vertices of a triangle lie inside the plane.
    localparam logic [1:0] CASE_NONE = 2'd0;
    localparam logic [1:0] CASE_ONE  = 2'd1;
    localparam logic [1:0] CASE_TWO  = 2'd2;
    localparam logic [1:0] CASE_ALL  = 2'd3;

    typedef logic signed [CW-1:0] t_coord;
    typedef logic [2:0][CW-1:0]   t_vtx;   // [0] x, [1] y, [2] z

    typedef struct packed {
        t_coord a_x; t_coord a_y; t_coord a_z;
        t_coord b_x; t_coord b_y; t_coord b_z;
        t_coord c_x; t_coord c_y; t_coord c_z;
    } t_tri_in;

    typedef struct packed {
        t_coord out_a_x; t_coord out_a_y; t_coord out_a_z;
        t_coord out_b_x; t_coord out_b_y; t_coord out_b_z;
        t_coord out_c_x; t_coord out_c_y; t_coord out_c_z;
        logic   piece;
        logic   last;
    } t_tri_out;

    // One axis of a cut: partial remainder, partial quotient, magnitude bits
    // still to feed (MSB first), sign of the edge delta and the start coordinate.
    typedef struct packed {
        logic [DW-1:0] r;
        logic [CW-1:0] q;
        logic [CW-1:0] m;
        logic          neg;
        logic [CW-1:0] s;
    } t_axis;

    typedef struct packed {
        logic [DW-1:0]  ds;
        logic [DW-1:0]  den;
        t_axis [2:0]    ax;
    } t_cut;

    function automatic t_cut cut_init(t_vtx s, t_vtx e, logic [DW-1:0] ds,
                                      logic [DW-1:0] de);
        t_cut        c;
        logic [CW:0] dl;
        logic [CW:0] mg;
        c.ds  = ds;
        c.den = ds - de;
        for (int k = 0; k < 3; k++) begin
            dl = {e[k][CW-1], e[k]} - {s[k][CW-1], s[k]};
            mg = dl[CW] ? (~dl + 1'b1) : dl;
            c.ax[k].r   = '0;
            c.ax[k].q   = '0;
            c.ax[k].m   = mg[CW-1:0];
            c.ax[k].neg = dl[CW];
            c.ax[k].s   = s[k];
        end
        return c;
    endfunction

    // One quotient bit per axis: shift in the next magnitude bit times ds,
    // then take off the divisor up to twice.
    function automatic t_cut cut_step(t_cut c);
        t_cut          n;
        logic [DW+1:0] tt;
        logic [DW+1:0] den1;
        logic [DW+1:0] den2;
        logic [1:0]    inc;
        n    = c;
        den1 = {2'b00, c.den};
        den2 = {1'b0, c.den, 1'b0};
        for (int k = 0; k < 3; k++) begin
            tt = {1'b0, c.ax[k].r, 1'b0} + (c.ax[k].m[CW-1] ? {2'b00, c.ds} : '0);
            if (tt >= den2) begin
                tt  = tt - den2;
                inc = 2'd2;
            end else if (tt >= den1) begin
                tt  = tt - den1;
                inc = 2'd1;
            end else begin
                inc = 2'd0;
            end
            n.ax[k].r = tt[DW-1:0];
            n.ax[k].q = {c.ax[k].q[CW-2:0], 1'b0} + CW'(inc);
            n.ax[k].m = {c.ax[k].m[CW-2:0], 1'b0};
        end
        return n;
    endfunction

    // Round to nearest, ties away from zero, and apply the offset to the start.
    function automatic t_vtx cut_finish(t_cut c);
        t_vtx        v;
        logic        rnd;
        logic [CW:0] off;
        logic [CW:0] sx;
        logic [CW:0] res;
        for (int k = 0; k < 3; k++) begin
            rnd = ({c.ax[k].r, 1'b0} >= {1'b0, c.den});
            off = {1'b0, c.ax[k].q} + {{CW{1'b0}}, rnd};
            sx  = {c.ax[k].s[CW-1], c.ax[k].s};
            res = c.ax[k].neg ? (sx - off) : (sx + off);
            v[k] = res[CW-1:0];
        end
        return v;
    endfunction

endpackage

@@ hw/rtl/triangle_plane_clip_core.sv @@
// Top level of the triangle plane clipper: config registers, distance and
// classify stages, two cut lanes (tpc_cut_pipe) and the output register. Uses tpc_pkg.
//
//   channel  | valid        | ready        | word
//   ---------+--------------+--------------+------------------------------------
//   config   | i_cfg_valid  | o_cfg_ready  | i_cfg_index, i_cfg_data
//   input    | i_valid      | o_ready      | i_tri (three vertices)
//   output   | o_valid      | i_ready      | o_tri (one triangle, piece, last)
//
// A triangle can enter every cycle unless the output stalls. One that yields
// two triangles holds the output register until both are taken, and no new
// input word enters until the second one goes.
// The whole pipeline advances on one enable; a stall at the output freezes
// every stage, so nothing is dropped or repeated. Reset is synchronous and
// clears the valid bits and loads the plane registers with their defaults.
`timescale 1ns / 1ps

module triangle_plane_clip_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tpc_pkg::CFG_IW-1:0]    i_cfg_index,
    input  logic [tpc_pkg::CW-1:0]        i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  tpc_pkg::t_tri_in              i_tri,
    output logic                          o_valid,
    input  logic                          i_ready,
    output tpc_pkg::t_tri_out             o_tri
);

    localparam int CW  = tpc_pkg::CW;
    localparam int PRW = tpc_pkg::PRW;
    localparam int DW  = tpc_pkg::DW;

    // Plane point and inward normal.
    tpc_pkg::t_vtx r_plane;
    tpc_pkg::t_vtx r_normal;

    // Pipeline control.
    logic en;
    logic r_v1, r_v2, r_v3, r_v4;
    logic r_dv_v [CW];
    logic r_o_v, r_o_phase, r_o_two;

    // Pipeline payload.
    tpc_pkg::t_vtx     r1_tri [3];
    logic [2:0][CW:0]  r1_diff [3];
    tpc_pkg::t_vtx     r2_tri [3];
    logic [2:0][PRW-1:0] r2_prod [3];
    tpc_pkg::t_vtx     r3_tri [3];
    logic [DW-1:0]     r3_dist [3];
    tpc_pkg::t_vtx     r4_p0, r4_p1, r4_p2;
    logic [1:0]        r4_case;
    tpc_pkg::t_cut     r4_cut_a, r4_cut_b;
    tpc_pkg::t_vtx     r_dv_p0 [CW];
    tpc_pkg::t_vtx     r_dv_p1 [CW];
    tpc_pkg::t_vtx     r_dv_p2 [CW];
    logic [1:0]        r_dv_case [CW];
    tpc_pkg::t_tri_out r_o_t0, r_o_t1;

    tpc_pkg::t_cut cut_a_out, cut_b_out;

    function automatic tpc_pkg::t_tri_out mk_tri(tpc_pkg::t_vtx a, tpc_pkg::t_vtx b,
                                                 tpc_pkg::t_vtx c, logic pc, logic lst);
        tpc_pkg::t_tri_out t;
        t.out_a_x = a[0]; t.out_a_y = a[1]; t.out_a_z = a[2];
        t.out_b_x = b[0]; t.out_b_y = b[1]; t.out_b_z = b[2];
        t.out_c_x = c[0]; t.out_c_y = c[1]; t.out_c_z = c[2];
        t.piece   = pc;
        t.last    = lst;
        return t;
    endfunction

    // The pipeline moves when the output register is empty or gives up its
    // final triangle in this cycle.
    assign en          = !r_o_v || (i_ready && (r_o_phase || !r_o_two));
    assign o_ready     = en;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_o_v;
    assign o_tri       = r_o_phase ? r_o_t1 : r_o_t0;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane  <= '0;
            r_normal <= {{CW{1'b0}}, {CW{1'b0}}, CW'(65536)};
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tpc_pkg::REG_PLANE_X:  r_plane[0]  <= i_cfg_data;
                tpc_pkg::REG_PLANE_Y:  r_plane[1]  <= i_cfg_data;
                tpc_pkg::REG_PLANE_Z:  r_plane[2]  <= i_cfg_data;
                tpc_pkg::REG_NORMAL_X: r_normal[0] <= i_cfg_data;
                tpc_pkg::REG_NORMAL_Y: r_normal[1] <= i_cfg_data;
                tpc_pkg::REG_NORMAL_Z: r_normal[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage 4 classification: the inside mask picks the cut edges.
    logic [2:0]    in_mask;
    logic [1:0]    n_case;
    logic [1:0]    i0, i1, o0, o1;
    tpc_pkg::t_vtx n_p0, n_p1;
    tpc_pkg::t_cut n_cut_a, n_cut_b;

    always_comb begin
        for (int v = 0; v < 3; v++) begin
            in_mask[v] = !r3_dist[v][DW-1];
        end
        i0 = 2'd0; i1 = 2'd1; o0 = 2'd2; o1 = 2'd2;
        n_case = tpc_pkg::CASE_NONE;
        case (in_mask)
            3'b001: begin n_case = tpc_pkg::CASE_ONE; i0 = 2'd0; o0 = 2'd1; o1 = 2'd2; end
            3'b010: begin n_case = tpc_pkg::CASE_ONE; i0 = 2'd1; o0 = 2'd0; o1 = 2'd2; end
            3'b100: begin n_case = tpc_pkg::CASE_ONE; i0 = 2'd2; o0 = 2'd0; o1 = 2'd1; end
            3'b011: begin n_case = tpc_pkg::CASE_TWO; i0 = 2'd0; i1 = 2'd1; o0 = 2'd2; end
            3'b101: begin n_case = tpc_pkg::CASE_TWO; i0 = 2'd0; i1 = 2'd2; o0 = 2'd1; end
            3'b110: begin n_case = tpc_pkg::CASE_TWO; i0 = 2'd1; i1 = 2'd2; o0 = 2'd0; end
            3'b111: n_case = tpc_pkg::CASE_ALL;
            default: n_case = tpc_pkg::CASE_NONE;
        endcase
        n_cut_a = tpc_pkg::cut_init(r3_tri[i0], r3_tri[o0], r3_dist[i0], r3_dist[o0]);
        if (n_case == tpc_pkg::CASE_TWO) begin
            n_cut_b = tpc_pkg::cut_init(r3_tri[i1], r3_tri[o0], r3_dist[i1], r3_dist[o0]);
        end else begin
            n_cut_b = tpc_pkg::cut_init(r3_tri[i0], r3_tri[o1], r3_dist[i0], r3_dist[o1]);
        end
        n_p0 = (n_case == tpc_pkg::CASE_ALL) ? r3_tri[0] : r3_tri[i0];
        n_p1 = (n_case == tpc_pkg::CASE_ALL) ? r3_tri[1] : r3_tri[i1];
    end

    // Stage 2 products, with explicit sign extension to the full width.
    logic signed [PRW-1:0] ext_n [3];
    logic signed [PRW-1:0] ext_d [3][3];
    logic        [DW-1:0]  n_dist [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ext_n[k] = {{(PRW-CW){r_normal[k][CW-1]}}, r_normal[k]};
        end
        for (int v = 0; v < 3; v++) begin
            for (int k = 0; k < 3; k++) begin
                ext_d[v][k] = {{(PRW-CW-1){r1_diff[v][k][CW]}}, r1_diff[v][k]};
            end
            n_dist[v] = {{(DW-PRW){r2_prod[v][0][PRW-1]}}, r2_prod[v][0]}
                      + {{(DW-PRW){r2_prod[v][1][PRW-1]}}, r2_prod[v][1]}
                      + {{(DW-PRW){r2_prod[v][2][PRW-1]}}, r2_prod[v][2]};
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_tri[0] <= {i_tri.a_z, i_tri.a_y, i_tri.a_x};
            r1_tri[1] <= {i_tri.b_z, i_tri.b_y, i_tri.b_x};
            r1_tri[2] <= {i_tri.c_z, i_tri.c_y, i_tri.c_x};
            r1_diff[0][0] <= {i_tri.a_x[CW-1], i_tri.a_x} - {r_plane[0][CW-1], r_plane[0]};
            r1_diff[0][1] <= {i_tri.a_y[CW-1], i_tri.a_y} - {r_plane[1][CW-1], r_plane[1]};
            r1_diff[0][2] <= {i_tri.a_z[CW-1], i_tri.a_z} - {r_plane[2][CW-1], r_plane[2]};
            r1_diff[1][0] <= {i_tri.b_x[CW-1], i_tri.b_x} - {r_plane[0][CW-1], r_plane[0]};
            r1_diff[1][1] <= {i_tri.b_y[CW-1], i_tri.b_y} - {r_plane[1][CW-1], r_plane[1]};
            r1_diff[1][2] <= {i_tri.b_z[CW-1], i_tri.b_z} - {r_plane[2][CW-1], r_plane[2]};
            r1_diff[2][0] <= {i_tri.c_x[CW-1], i_tri.c_x} - {r_plane[0][CW-1], r_plane[0]};
            r1_diff[2][1] <= {i_tri.c_y[CW-1], i_tri.c_y} - {r_plane[1][CW-1], r_plane[1]};
            r1_diff[2][2] <= {i_tri.c_z[CW-1], i_tri.c_z} - {r_plane[2][CW-1], r_plane[2]};

            for (int v = 0; v < 3; v++) begin
                r2_tri[v] <= r1_tri[v];
                for (int k = 0; k < 3; k++) begin
                    r2_prod[v][k] <= ext_n[k] * ext_d[v][k];
                end
                r3_tri[v]  <= r2_tri[v];
                r3_dist[v] <= n_dist[v];
            end

            r4_case  <= n_case;
            r4_p0    <= n_p0;
            r4_p1    <= n_p1;
            r4_p2    <= r3_tri[2];
            r4_cut_a <= n_cut_a;
            r4_cut_b <= n_cut_b;

            // Side channel that rides along with the cut lanes. It starts from
            // the classify-stage registers so it lines up with the lane outputs.
            r_dv_p0[0]   <= r4_p0;
            r_dv_p1[0]   <= r4_p1;
            r_dv_p2[0]   <= r4_p2;
            r_dv_case[0] <= r4_case;
            for (int k = 1; k < CW; k++) begin
                r_dv_p0[k]   <= r_dv_p0[k-1];
                r_dv_p1[k]   <= r_dv_p1[k-1];
                r_dv_p2[k]   <= r_dv_p2[k-1];
                r_dv_case[k] <= r_dv_case[k-1];
            end
        end
    end

    // The classify stage registers the lane inputs; the lanes start one
    // stage later so the side channel has the same depth.
    tpc_cut_pipe u_cut_a (
        .i_clk (i_clk),
        .i_en  (en),
        .i_cut (r4_cut_a),
        .o_cut (cut_a_out)
    );

    tpc_cut_pipe u_cut_b (
        .i_clk (i_clk),
        .i_en  (en),
        .i_cut (r4_cut_b),
        .o_cut (cut_b_out)
    );

    // Output assembly from the last divider stage.
    tpc_pkg::t_vtx     xa, xb;
    tpc_pkg::t_vtx     e_p0, e_p1, e_p2;
    logic [1:0]        e_case;
    tpc_pkg::t_tri_out n_t0, n_t1;

    assign xa     = tpc_pkg::cut_finish(cut_a_out);
    assign xb     = tpc_pkg::cut_finish(cut_b_out);
    assign e_p0   = r_dv_p0[CW-1];
    assign e_p1   = r_dv_p1[CW-1];
    assign e_p2   = r_dv_p2[CW-1];
    assign e_case = r_dv_case[CW-1];

    always_comb begin
        n_t1 = mk_tri(e_p1, xa, xb, 1'b1, 1'b1);
        case (e_case)
            tpc_pkg::CASE_ALL: n_t0 = mk_tri(e_p0, e_p1, e_p2, 1'b0, 1'b1);
            tpc_pkg::CASE_ONE: n_t0 = mk_tri(e_p0, xa, xb, 1'b0, 1'b1);
            tpc_pkg::CASE_TWO: n_t0 = mk_tri(e_p0, e_p1, xa, 1'b0, 1'b0);
            default:           n_t0 = mk_tri(e_p0, e_p1, e_p2, 1'b0, 1'b1);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_t0 <= n_t0;
            r_o_t1 <= n_t1;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_o_v     <= 1'b0;
            r_o_phase <= 1'b0;
            r_o_two   <= 1'b0;
            for (int k = 0; k < CW; k++) begin
                r_dv_v[k] <= 1'b0;
            end
        end else if (en) begin
            r_v1      <= i_valid;
            r_v2      <= r_v1;
            r_v3      <= r_v2;
            r_v4      <= r_v3;
            r_dv_v[0] <= r_v4;
            for (int k = 1; k < CW; k++) begin
                r_dv_v[k] <= r_dv_v[k-1];
            end
            r_o_v     <= r_dv_v[CW-1] && (e_case != tpc_pkg::CASE_NONE);
            r_o_phase <= 1'b0;
            r_o_two   <= (e_case == tpc_pkg::CASE_TWO);
        end else if (r_o_v && i_ready) begin
            r_o_phase <= 1'b1;
        end
    end

endmodule

@@ hw/rtl/tpc_cut_pipe.sv @@
// Pipelined restoring divider for one cut lane, one quotient bit per stage.
// Depends on tpc_pkg for the lane type and step function.
`timescale 1ns / 1ps

module tpc_cut_pipe (
    input  logic          i_clk,
    input  logic          i_en,
    input  tpc_pkg::t_cut i_cut,
    output tpc_pkg::t_cut o_cut
);

    tpc_pkg::t_cut r_stg [tpc_pkg::CW];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stg[0] <= tpc_pkg::cut_step(i_cut);
            for (int k = 1; k < tpc_pkg::CW; k++) begin
                r_stg[k] <= tpc_pkg::cut_step(r_stg[k-1]);
            end
        end
    end

    assign o_cut = r_stg[tpc_pkg::CW-1];

endmodule
